@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sparse coordinate table.
// No dependencies; each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a holds -> b holds in the same cycle
`define SCT_ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("implication check failed");

// a holds -> b holds in the next cycle
`define SCT_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("next-cycle check failed");

// a never holds
`define SCT_ASSERT_NEVER(label, clk, rstn, a) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(a)) \
        else $error("forbidden condition seen");

`else

`define SCT_ASSERT_IMPLIES(label, clk, rstn, a, b)
`define SCT_ASSERT_NEXT(label, clk, rstn, a, b)
`define SCT_ASSERT_NEVER(label, clk, rstn, a)

`endif

`endif

@@ rtl/sct_pkg.sv @@
// Types, codes and sizes for the sparse coordinate table.
// No dependencies; used by sparse_coordinate_table_core.
package sct_pkg;

    localparam int DEPTH      = 64;
    localparam int COORD_BITS = 8;
    localparam int VAL_W      = 32;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int EXT_W   = COORD_BITS + 1;
    localparam int ENTRY_W = 2 * COORD_BITS + VAL_W;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // stream packing (field widths fixed by the interface)
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;
    localparam int CMD_LSB  = 0;
    localparam int ROW_LSB  = 2;
    localparam int COL_LSB  = 10;
    localparam int VAL_LSB  = 18;

    localparam int RES_EXT_W = 9;
    localparam int RES_CNT_W = 7;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_ACCUM  = 2'd2,
        CMD_QUERY  = 2'd3
    } sct_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_SAT  = 2'd2
    } sct_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACC_WR,
        ST_DONE
    } sct_state_t;

    typedef struct packed {
        sct_cmd_t               cmd;
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  col;
        logic signed [VAL_W-1:0] value;
    } sct_req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  col;
        logic signed [VAL_W-1:0] value;
    } sct_entry_t;

endpackage

@@ rtl/sparse_coordinate_table_core.sv @@
// Sparse coordinate table: (row, col, value) list in one synchronous RAM.
// Depends on sct_pkg and assert_macros.svh.
//
// Usage:
//   Input stream s_axis_*: one transfer carries cmd, row, col and value.
//   Output stream m_axis_*: exactly one result transfer per input transfer,
//   in order, carrying the queried value, found flag, extents, entry count
//   and status.
//   Clear, append and a query outside the extents go from the input transfer
//   straight to the done state, where the result is loaded into the output
//   register once it is free. Accumulate and query walk the stored entries
//   one per cycle through the registered RAM read port. The block works on
//   one item at a time; s_axis_tready is high while it waits for a command.
//   The output register decouples the sides: a new command is accepted while
//   a result waits. If the receiver stalls and the next result is ready, the
//   block holds it and stops accepting until the output register frees up.
//   Reset (aresetn low, synchronous) empties the table and clears both
//   extents; the RAM itself is not cleared, only entries below the entry count
//   are matched.
`include "assert_macros.svh"

module sparse_coordinate_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cmd[1:0], row[9:2], col[17:10], value[49:18], zero fill[55:50]
    input  logic [sct_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_value[31:0], found[32], row_extent[41:33], col_extent[50:42],
    // stored_count[57:51], status[59:58], zero fill[63:60]
    output logic [sct_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int ADDR_W = sct_pkg::ADDR_W;
    localparam int CNT_W  = sct_pkg::CNT_W;
    localparam int EXT_W  = sct_pkg::EXT_W;
    localparam int VAL_W  = sct_pkg::VAL_W;
    localparam int CB     = sct_pkg::COORD_BITS;

    // entry RAM
    sct_pkg::sct_entry_t mem [sct_pkg::DEPTH];
    sct_pkg::sct_entry_t mem_q;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    sct_pkg::sct_entry_t wr_data;

    sct_pkg::sct_state_t  state_reg, state_next;
    sct_pkg::sct_req_t    req_reg, req_next, req_in;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [EXT_W-1:0]     row_bnd_reg, row_bnd_next;
    logic [EXT_W-1:0]     col_bnd_reg, col_bnd_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    hit_addr_reg, hit_addr_next;
    logic signed [VAL_W-1:0] hit_val_reg, hit_val_next;
    logic signed [VAL_W-1:0] res_val_reg, res_val_next;
    logic                 found_reg, found_next;
    sct_pkg::sct_status_t status_reg, status_next;
    logic                 m_vld_reg, m_vld_next;
    logic [sct_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic s_xfer;
    logic in_ext;
    logic hit;
    logic scan_done;
    logic out_free;

    logic              do_push;
    logic [CB-1:0]     push_row, push_col;
    logic signed [VAL_W-1:0] push_val;

    logic signed [VAL_W:0]   sum_wide;
    logic                    sum_ovf;
    logic signed [VAL_W-1:0] sum_sat;

    assign req_in.cmd   = sct_pkg::sct_cmd_t'(s_axis_tdata[sct_pkg::CMD_LSB +: 2]);
    assign req_in.row   = s_axis_tdata[sct_pkg::ROW_LSB +: CB];
    assign req_in.col   = s_axis_tdata[sct_pkg::COL_LSB +: CB];
    assign req_in.value = s_axis_tdata[sct_pkg::VAL_LSB +: VAL_W];

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_vld_reg || m_axis_tready;

    assign in_ext = ({1'b0, req_in.row} < row_bnd_reg) && ({1'b0, req_in.col} < col_bnd_reg);

    // pend_reg: mem_q holds entry scan_idx_reg-1
    assign hit       = pend_reg && (mem_q.row == req_reg.row) && (mem_q.col == req_reg.col);
    assign scan_done = (scan_idx_reg >= count_reg);

    assign sum_wide = {hit_val_reg[VAL_W-1], hit_val_reg}
                    + {req_reg.value[VAL_W-1], req_reg.value};
    assign sum_ovf  = (sum_wide[VAL_W] != sum_wide[VAL_W-1]);
    assign sum_sat  = !sum_ovf ? sum_wide[VAL_W-1:0]
                    : (sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                       : {1'b0, {(VAL_W-1){1'b1}}});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sct_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    unique case (req_in.cmd)
                        sct_pkg::CMD_CLEAR,
                        sct_pkg::CMD_APPEND: state_next = sct_pkg::ST_DONE;
                        sct_pkg::CMD_ACCUM:  state_next = sct_pkg::ST_SCAN;
                        sct_pkg::CMD_QUERY:  state_next = in_ext ? sct_pkg::ST_SCAN
                                                                 : sct_pkg::ST_DONE;
                        default:             state_next = sct_pkg::ST_DONE;
                    endcase
                end
            end
            sct_pkg::ST_SCAN: begin
                if (req_reg.cmd == sct_pkg::CMD_ACCUM && hit) begin
                    state_next = sct_pkg::ST_ACC_WR;
                end else if (scan_done) begin
                    state_next = sct_pkg::ST_DONE;
                end
            end
            sct_pkg::ST_ACC_WR: state_next = sct_pkg::ST_DONE;
            sct_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sct_pkg::ST_IDLE;
                end
            end
            default: state_next = sct_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (state_reg == sct_pkg::ST_IDLE);
        rd_addr       = scan_idx_reg[ADDR_W-1:0];
        m_axis_tvalid = m_vld_reg;
        m_axis_tdata  = m_data_reg;
    end

    // datapath
    always_comb begin
        req_next      = req_reg;
        count_next    = count_reg;
        row_bnd_next  = row_bnd_reg;
        col_bnd_next  = col_bnd_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        hit_addr_next = hit_addr_reg;
        hit_val_next  = hit_val_reg;
        res_val_next  = res_val_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = '{row: req_reg.row, col: req_reg.col, value: sum_sat};
        do_push       = 1'b0;
        push_row      = req_reg.row;
        push_col      = req_reg.col;
        push_val      = req_reg.value;

        case (state_reg)
            sct_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    req_next      = req_in;
                    res_val_next  = '0;
                    found_next    = 1'b0;
                    status_next   = sct_pkg::STAT_OK;
                    scan_idx_next = '0;
                    case (req_in.cmd)
                        sct_pkg::CMD_CLEAR: begin
                            count_next   = '0;
                            row_bnd_next = '0;
                            col_bnd_next = '0;
                        end
                        sct_pkg::CMD_APPEND: begin
                            do_push  = 1'b1;
                            push_row = req_in.row;
                            push_col = req_in.col;
                            push_val = req_in.value;
                        end
                        default: ;
                    endcase
                end
            end
            sct_pkg::ST_SCAN: begin
                if (req_reg.cmd == sct_pkg::CMD_ACCUM && hit) begin
                    // earliest match wins; stop here
                    hit_addr_next = ADDR_W'(scan_idx_reg - CNT_W'(1));
                    hit_val_next  = mem_q.value;
                end else begin
                    if (hit) begin
                        // query keeps the latest match
                        res_val_next = mem_q.value;
                        found_next   = 1'b1;
                    end
                    if (!scan_done) begin
                        pend_next     = 1'b1;
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end else if (req_reg.cmd == sct_pkg::CMD_ACCUM) begin
                        do_push = 1'b1;
                    end
                end
            end
            sct_pkg::ST_ACC_WR: begin
                mem_we  = 1'b1;
                wr_addr = hit_addr_reg;
                if (sum_ovf) begin
                    status_next = sct_pkg::STAT_SAT;
                end
            end
            default: ;
        endcase

        if (do_push) begin
            if (count_reg < sct_pkg::DEPTH_C) begin
                mem_we     = 1'b1;
                wr_addr    = count_reg[ADDR_W-1:0];
                wr_data    = '{row: push_row, col: push_col, value: push_val};
                count_next = count_reg + CNT_W'(1);
                if ({1'b0, push_row} + EXT_W'(1) > row_bnd_reg) begin
                    row_bnd_next = {1'b0, push_row} + EXT_W'(1);
                end
                if ({1'b0, push_col} + EXT_W'(1) > col_bnd_reg) begin
                    col_bnd_next = {1'b0, push_col} + EXT_W'(1);
                end
            end else begin
                status_next = sct_pkg::STAT_FULL;
            end
        end

        // output register
        if (m_vld_reg && m_axis_tready) begin
            m_vld_next = 1'b0;
        end
        if (state_reg == sct_pkg::ST_DONE && out_free) begin
            m_vld_next  = 1'b1;
            m_data_next = {4'b0000,
                           status_reg,
                           sct_pkg::RES_CNT_W'(count_reg),
                           sct_pkg::RES_EXT_W'(col_bnd_reg),
                           sct_pkg::RES_EXT_W'(row_bnd_reg),
                           found_reg,
                           res_val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sct_pkg::ST_IDLE;
            count_reg   <= '0;
            row_bnd_reg <= '0;
            col_bnd_reg <= '0;
            pend_reg    <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            row_bnd_reg <= row_bnd_next;
            col_bnd_reg <= col_bnd_next;
            pend_reg    <= pend_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        hit_addr_reg <= hit_addr_next;
        hit_val_reg  <= hit_val_next;
        res_val_reg  <= res_val_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    `SCT_ASSERT_NEVER(a_count_max, aclk, aresetn, count_reg > sct_pkg::DEPTH_C)
    `SCT_ASSERT_IMPLIES(a_empty_ext, aclk, aresetn, count_reg == '0,
                        (row_bnd_reg == '0) && (col_bnd_reg == '0))
    `SCT_ASSERT_IMPLIES(a_scan_bound, aclk, aresetn, state_reg == sct_pkg::ST_SCAN,
                        scan_idx_reg <= count_reg)
    `SCT_ASSERT_NEXT(a_acc_wr_done, aclk, aresetn, state_reg == sct_pkg::ST_ACC_WR,
                     state_reg == sct_pkg::ST_DONE)

endmodule
